@@ hw/rtl/chs_pkg.sv @@
// Shared types and constants for the chained hash set core.
package chs_pkg;

	localparam int KEY_W = 31;
	localparam int ACT_W = 2;
	localparam int TS_W  = 4;

	localparam logic [TS_W-1:0] TS_RESET = 4'd7;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic clr_step;
		logic eval;
		logic out_load;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic div_last;
		logic clr_last;
		logic stop;
	} sts_t;

endpackage

@@ hw/rtl/chs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module chs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ hw/rtl/chs_ctrl.sv @@
// Request sequencer: clear pass, modulo, slot scan, result hand-off.
module chs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output chs_pkg::cmd_t cmd,
	input  chs_pkg::sts_t sts
);

	import chs_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_EVAL,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR:  cmd.clr_step = 1'b1;
			ST_IDLE:   cmd.load     = in_valid;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_READ:   ;
			ST_EVAL:   cmd.eval     = 1'b1;
			ST_FINISH: cmd.out_load = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= sts.stop ? ST_FINISH : ST_READ;
				end
				ST_FINISH: begin
					if (cmd.out_load) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/chs_dp.sv @@
// Datapath: config register, bit-serial modulo, slot table and result registers.
module chs_dp #(
	parameter int BUCKETS          = 8,
	parameter int SLOTS_PER_BUCKET = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  chs_pkg::cmd_t               cmd,
	output chs_pkg::sts_t               sts,
	input  logic                        cfg_we,
	input  logic [chs_pkg::TS_W-1:0]    table_size,
	input  logic [chs_pkg::ACT_W-1:0]   action,
	input  logic [chs_pkg::KEY_W-1:0]   key,
	output logic                        found,
	output logic                        status
);

	import chs_pkg::*;

	localparam int TOTAL  = BUCKETS * SLOTS_PER_BUCKET;
	localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int CNT_W  = $clog2(KEY_W);
	localparam int CLAMP  = (BUCKETS < 15) ? BUCKETS : 15;
	localparam logic [TS_W-1:0]   CLAMP_TS   = TS_W'(CLAMP);
	localparam logic [ADDR_W-1:0] SLOTS_A    = ADDR_W'(SLOTS_PER_BUCKET);
	localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(TOTAL - 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS_PER_BUCKET - 1);
	localparam logic [CNT_W-1:0]  LAST_STEP  = CNT_W'(KEY_W - 1);

	logic [TS_W-1:0]   table_size_q;
	logic [TS_W-1:0]   eff_size;
	logic [TS_W-1:0]   divisor_q;
	logic [TS_W-1:0]   rem_q;
	logic [KEY_W-1:0]  dividend_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic [ACT_W-1:0]  action_q;
	logic [KEY_W-1:0]  key_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ADDR_W-1:0] clr_q;
	logic              found_acc_q;
	logic              full_acc_q;
	logic              found_q;
	logic              status_q;

	logic [TS_W:0]     trial;
	logic [ADDR_W-1:0] slot_addr;
	logic              slot_last;
	logic [KEY_W:0]    rd_data;
	logic              entry_valid;
	logic              hit;
	logic              ev_wr;
	logic              ev_set;
	logic              ev_found;
	logic              ev_full;
	logic              ev_stop;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [KEY_W:0]    ram_wdata;

	assign eff_size = (table_size_q == '0) ? TS_W'(1) :
	                  (table_size_q > CLAMP_TS) ? CLAMP_TS : table_size_q;

	assign trial     = {rem_q, dividend_q[KEY_W-1]};
	assign slot_addr = ADDR_W'(rem_q) * SLOTS_A + ADDR_W'(slot_q);
	assign slot_last = (slot_q == LAST_SLOT);

	assign entry_valid = rd_data[KEY_W];
	assign hit         = entry_valid && (rd_data[KEY_W-1:0] == key_q);

	always_comb begin
		ev_wr    = 1'b0;
		ev_set   = 1'b0;
		ev_found = 1'b0;
		ev_full  = 1'b0;
		ev_stop  = 1'b0;
		case (action_q)
			ACT_INSERT: begin
				if (!entry_valid) begin
					ev_wr   = 1'b1;
					ev_set  = 1'b1;
					ev_stop = 1'b1;
				end else if (slot_last) begin
					ev_full = 1'b1;
					ev_stop = 1'b1;
				end
			end
			ACT_SEARCH: begin
				if (hit) begin
					ev_found = 1'b1;
					ev_stop  = 1'b1;
				end else if (slot_last) begin
					ev_stop = 1'b1;
				end
			end
			ACT_DELETE: begin
				ev_wr   = hit;
				ev_stop = slot_last;
			end
			default: begin
				ev_stop = 1'b1;
			end
		endcase
	end

	assign ram_we    = cmd.clr_step || (cmd.eval && ev_wr);
	assign ram_waddr = cmd.clr_step ? clr_q : slot_addr;
	assign ram_wdata = (cmd.clr_step || !ev_set) ? '0 : {1'b1, key_q};

	chs_ram #(
		.WIDTH(KEY_W + 1),
		.DEPTH(TOTAL)
	) u_slots (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(slot_addr),
		.rd_data(rd_data)
	);

	assign sts.div_last = (div_cnt_q == LAST_STEP);
	assign sts.clr_last = (clr_q == LAST_ADDR);
	assign sts.stop     = ev_stop;

	assign found  = found_q;
	assign status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TS_RESET;
			clr_q        <= '0;
		end else begin
			if (cfg_we) table_size_q <= table_size;
			if (cmd.clr_step) clr_q <= clr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q    <= action;
			key_q       <= key;
			dividend_q  <= key;
			divisor_q   <= eff_size;
			rem_q       <= '0;
			div_cnt_q   <= '0;
			slot_q      <= '0;
			found_acc_q <= 1'b0;
			full_acc_q  <= 1'b0;
		end else if (cmd.div_step) begin
			dividend_q <= dividend_q << 1;
			div_cnt_q  <= div_cnt_q + CNT_W'(1);
			if (trial >= {1'b0, divisor_q}) begin
				rem_q <= TS_W'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[TS_W-1:0];
			end
		end else if (cmd.eval) begin
			if (ev_found) found_acc_q <= 1'b1;
			if (ev_full) full_acc_q <= 1'b1;
			if (!ev_stop) slot_q <= slot_q + SLOT_W'(1);
		end
		if (cmd.out_load) begin
			found_q  <= found_acc_q;
			status_q <= full_acc_q;
		end
	end

endmodule

@@ hw/rtl/chained_hash_set_core.sv @@
// Top level of the chained hash set: controller plus datapath.
//
//  channel | signals                    | beat carries
//  --------+----------------------------+------------------------
//  cfg     | cfg_valid / cfg_ready      | table_size
//  in      | in_valid / in_ready        | action, key
//  out     | out_valid / out_ready      | found, status
//
// Per request: accept, bit-serial modulo, a read and a check per slot scanned,
// then hand-off. After reset a clearing pass writes every slot, with in_ready
// low. cfg_ready is always high.
// A request is taken while the previous result waits in the output register;
// it stalls at hand-off only if that result is still not taken.
module chained_hash_set_core #(
	parameter int BUCKETS          = 8,
	parameter int SLOTS_PER_BUCKET = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [chs_pkg::TS_W-1:0]    table_size,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [chs_pkg::ACT_W-1:0]   action,
	input  logic [chs_pkg::KEY_W-1:0]   key,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic                        status
);

	import chs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	chs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	chs_dp #(
		.BUCKETS         (BUCKETS),
		.SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid && cfg_ready),
		.table_size(table_size),
		.action    (action),
		.key       (key),
		.found     (found),
		.status    (status)
	);

endmodule

@@ hw/rtl/chs_checker.sv @@
// Port-level checker for the chained hash set core, with its bind.
module chs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic found,
	input logic status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(status))
		else $error("result changed or dropped while stalled");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && status))
		else $error("found and status both set");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in progress");

	a_no_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 !$rose(out_valid))
		else $error("result appeared before the modulo could finish");

endmodule

bind chained_hash_set_core chs_checker u_chs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.found    (found),
	.status   (status)
);
